// ===== sv/pfc_pkg.sv =====
package pfc_pkg;

    localparam int ALPHABET = 26;
    localparam int CELLS    = 25;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_rc;

    localparam t_letter LETTER_I      = 5'd8;
    localparam t_letter LETTER_J      = 5'd9;
    localparam t_letter FILLER_LETTER = 5'd23;
    localparam t_letter LAST_LETTER   = 5'd25;
    localparam t_letter LAST_CELL     = 5'd24;
    localparam t_rc     SIDE_MAX      = 3'd4;

    localparam logic [2:0] REQ_KEY_START   = 3'd0;
    localparam logic [2:0] REQ_KEY_LETTER  = 3'd1;
    localparam logic [2:0] REQ_KEY_END     = 3'd2;
    localparam logic [2:0] REQ_TEXT_LETTER = 3'd3;
    localparam logic [2:0] REQ_TEXT_END    = 3'd4;

    typedef struct packed {
        logic key_start;
        logic key_letter;
        logic fill_start;
        logic fill_step;
        logic text_letter;
        logic text_end;
        logic read_pos;
        logic read_sq;
    } t_cmd;

    typedef struct packed {
        logic pend_valid;
        logic letter_ok;
        logic fill_last;
        logic out_empty;
    } t_sts;

    function automatic t_letter fold_j(input t_letter c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // square position 0..24 -> row
    function automatic t_rc pos_row(input t_letter p);
        t_rc r;
        priority if (p >= 5'd20) r = 3'd4;
        else if (p >= 5'd15)     r = 3'd3;
        else if (p >= 5'd10)     r = 3'd2;
        else if (p >= 5'd5)      r = 3'd1;
        else                     r = 3'd0;
        return r;
    endfunction

    function automatic t_rc pos_col(input t_letter p);
        t_letter base;
        t_letter diff;
        base = {pos_row(p), 2'b00} + {2'b00, pos_row(p)};
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic t_letter cell_idx(input t_rc row, input t_rc col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // one step around a row or column, forward or backward
    function automatic t_rc wrap_step(input t_rc v, input logic dec);
        t_rc r;
        if (dec) begin
            r = (v == 3'd0) ? SIDE_MAX : v - 3'd1;
        end else begin
            r = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== sv/pfc_req_if.sv =====
interface pfc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [4:0] letter;

    modport source (output valid, output req_type, output letter, input ready);
    modport sink   (input valid, input req_type, input letter, output ready);
endinterface

// ===== sv/pfc_rsp_if.sv =====
interface pfc_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_letter;
    logic       last;

    modport source (output valid, output out_letter, output last, input ready);
    modport sink   (input valid, input out_letter, input last, output ready);
endinterface

// ===== sv/pfc_ctrl.sv =====
module pfc_ctrl
    import pfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [2:0] i_req_type,
    output logic       o_req_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_POS  = 2'd2;
    localparam logic [1:0] S_SQ   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       fire;

    assign o_req_ready = (r_state == S_IDLE);
    assign fire        = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (fire) begin
                    unique case (i_req_type)
                        REQ_KEY_START:  o_cmd.key_start  = 1'b1;
                        REQ_KEY_LETTER: o_cmd.key_letter = 1'b1;
                        REQ_KEY_END: begin
                            o_cmd.fill_start = 1'b1;
                            n_state          = S_FILL;
                        end
                        REQ_TEXT_LETTER: begin
                            o_cmd.text_letter = 1'b1;
                            if (i_sts.pend_valid && i_sts.letter_ok) n_state = S_POS;
                        end
                        REQ_TEXT_END: begin
                            o_cmd.text_end = 1'b1;
                            if (i_sts.pend_valid) n_state = S_POS;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            S_POS: begin
                o_cmd.read_pos = 1'b1;
                n_state        = S_SQ;
            end
            S_SQ: begin
                // hold the pair until the previous one has drained
                if (i_sts.out_empty) begin
                    o_cmd.read_sq = 1'b1;
                    n_state       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/pfc_dp.sv =====
module pfc_dp
    import pfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_letter i_letter,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output logic    o_out_valid,
    output t_letter o_out_letter,
    output logic    o_out_last,
    input  logic    i_out_ready
);

    t_letter r_sq [CELLS];
    t_letter r_pos [ALPHABET];

    logic                r_mode;
    logic [ALPHABET-1:0] r_used;
    t_letter             r_fill;
    t_letter             r_fill_idx;
    logic                r_pend;
    t_letter             r_pend_letter;
    t_letter             r_a;
    t_letter             r_b;
    logic                r_last;
    t_letter             r_pa;
    t_letter             r_pb;
    t_letter             r_out_x;
    t_letter             r_out_y;
    logic                r_out_last;
    logic [1:0]          r_out_cnt;

    logic    letter_ok;
    t_letter text_c;
    t_letter place_c;
    logic    place_en;
    logic    do_place;
    t_rc     r1, c1, r2, c2;
    t_letter x_idx, y_idx;

    assign letter_ok = (i_letter <= LAST_LETTER);
    assign text_c    = fold_j(i_letter);

    assign o_sts.pend_valid = r_pend;
    assign o_sts.letter_ok  = letter_ok;
    assign o_sts.fill_last  = (r_fill_idx == LAST_LETTER);
    assign o_sts.out_empty  = (r_out_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // key placement: one letter per cycle from a key request or the fill walk
    assign place_c  = i_cmd.fill_step ? r_fill_idx : fold_j(i_letter);
    assign place_en = (i_cmd.key_letter && letter_ok) ||
                      (i_cmd.fill_step && (r_fill_idx != LETTER_J));
    assign do_place = place_en && (r_fill <= LAST_CELL) && !r_used[place_c];

    always_ff @(posedge i_clk) begin
        if (do_place) begin
            r_sq[r_fill]   <= place_c;
            r_pos[place_c] <= r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_fill     <= '0;
            r_fill_idx <= '0;
        end else begin
            if (i_cmd.key_start) begin
                r_used <= '0;
                r_fill <= '0;
            end else if (do_place) begin
                r_used[place_c] <= 1'b1;
                r_fill          <= r_fill + 5'd1;
            end
            if (i_cmd.fill_start) begin
                r_fill_idx <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill_idx <= r_fill_idx + 5'd1;
            end
        end
    end

    // pairing of text letters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= 1'b0;
            r_pend_letter <= '0;
        end else if (i_cmd.key_start) begin
            r_pend        <= 1'b0;
            r_pend_letter <= '0;
        end else if (i_cmd.text_letter && letter_ok) begin
            if (!r_pend) begin
                r_pend        <= 1'b1;
                r_pend_letter <= text_c;
            end else if (text_c == r_pend_letter) begin
                r_pend_letter <= text_c;
            end else begin
                r_pend        <= 1'b0;
                r_pend_letter <= '0;
            end
        end else if (i_cmd.text_end) begin
            r_pend        <= 1'b0;
            r_pend_letter <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.text_letter && letter_ok && r_pend) begin
            r_a    <= r_pend_letter;
            r_b    <= (text_c == r_pend_letter) ? FILLER_LETTER : text_c;
            r_last <= 1'b0;
        end else if (i_cmd.text_end && r_pend) begin
            r_a    <= r_pend_letter;
            r_b    <= FILLER_LETTER;
            r_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_pos) begin
            r_pa <= r_pos[r_a];
            r_pb <= r_pos[r_b];
        end
    end

    // Playfair rules; an equal pair falls into the same-row case
    assign r1 = pos_row(r_pa);
    assign c1 = pos_col(r_pa);
    assign r2 = pos_row(r_pb);
    assign c2 = pos_col(r_pb);

    always_comb begin
        priority if (r1 == r2) begin
            x_idx = cell_idx(r1, wrap_step(c1, r_mode));
            y_idx = cell_idx(r2, wrap_step(c2, r_mode));
        end else if (c1 == c2) begin
            x_idx = cell_idx(wrap_step(r1, r_mode), c1);
            y_idx = cell_idx(wrap_step(r2, r_mode), c2);
        end else begin
            x_idx = cell_idx(r1, c2);
            y_idx = cell_idx(r2, c1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_sq) begin
            r_out_x    <= r_sq[x_idx];
            r_out_y    <= r_sq[y_idx];
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (i_cmd.read_sq) begin
            r_out_cnt <= 2'd2;
        end else if (o_out_valid && i_out_ready) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    assign o_out_valid  = (r_out_cnt != 2'd0);
    assign o_out_letter = (r_out_cnt == 2'd2) ? r_out_x : r_out_y;
    assign o_out_last   = (r_out_cnt == 2'd1) && r_out_last;

endmodule

// ===== sv/playfair_digraph_cipher.sv =====
// Playfair cipher over a request stream. A key start, key letters and a key end build the
// 5x5 square; text letters then come out as enciphered (or, with i_cfg_wdata set to 1,
// deciphered) pairs, two responses per pair, with last set on the second letter of the pair
// that text end closes. Key start, key letter and single text letters leave the block idle.
// Key end starts a walk over the alphabet that visits one letter per cycle and writes each
// letter not yet placed, J excepted, into the square and position memories. A text letter
// or text end that completes a pair goes through accept, position memory read and square
// memory read into the output register, the last waiting until the previous pair is taken,
// as the output register holds one pair. Requests are accepted while a pair is held there.
// Change decrypt mode only while the block is idle; the block itself does not enforce this.
module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_req_if.sink   i_req,
    pfc_rsp_if.source o_rsp,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    pfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_letter     (i_req.letter),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_rsp.valid),
        .o_out_letter (o_rsp.out_letter),
        .o_out_last   (o_rsp.last),
        .i_out_ready  (o_rsp.ready)
    );

endmodule

// ===== sv/pfc_checker.sv =====
module pfc_checker
    import pfc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [2:0] i_req_type,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [4:0] i_rsp_letter,
    input logic       i_rsp_last
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_letter) && $stable(i_rsp_last))
        else $error("response changed while stalled");

    // the closing letter of a pair empties the output register
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready && i_rsp_last |=> !i_rsp_valid)
        else $error("response after the last letter of a pair");

    // the fill walk blocks requests
    a_key_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_type == REQ_KEY_END) |=> !i_req_ready)
        else $error("request taken during the key fill walk");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_req_ready && !i_rsp_valid)
        else $error("block not idle after reset");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_letter (o_rsp.out_letter),
    .i_rsp_last   (o_rsp.last)
);
